[rtl/iiel_pkg.sv]
// Shared types and codes for the indexed insert/erase list.
package iiel_pkg;

	// Payload field widths, fixed by the channel format
	localparam int REQ_TYPE_W = 2;
	localparam int POS_W      = 7;
	localparam int DATA_W     = 32;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;

	// Request kinds
	localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_ERASE  = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_MODIFY = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             era;
		logic             mdf;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

endpackage

[rtl/iiel_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface iiel_req_if;
	import iiel_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [POS_W-1:0]      position;
	logic [DATA_W-1:0]     value;
	modport source (output valid, req_type, position, value, input ready);
	modport sink (input valid, req_type, position, value, output ready);
endinterface

interface iiel_rsp_if;
	import iiel_pkg::*;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   read_value;
	logic [COUNT_W-1:0]  count;
	logic [STATUS_W-1:0] status;
	modport source (output valid, read_value, count, status, input ready);
	modport sink (input valid, read_value, count, status, output ready);
endinterface

[rtl/iiel_cell.sv]
// One list slot: holds an element and shifts to or from its neighbours.
module iiel_cell #(
	parameter int IDX        = 0,
	parameter int IW         = 7,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                    clk,
	input  iiel_pkg::cell_cmd_t     cmd,
	input  logic [ELEM_WIDTH-1:0]   value,
	input  logic [ELEM_WIDTH-1:0]   left,
	input  logic [ELEM_WIDTH-1:0]   right,
	output logic [ELEM_WIDTH-1:0]   data,
	output logic [ELEM_WIDTH-1:0]   rd_word
);
	import iiel_pkg::*;

	logic [ELEM_WIDTH-1:0] data_q;
	logic [IW-1:0]         pos_w;
	logic                  hit;
	logic                  above;

	// Where this slot sits relative to the requested position
	assign pos_w = IW'(cmd.pos);
	assign hit   = (pos_w == IW'(IDX));
	assign above = (pos_w < IW'(IDX));

	// Insert pulls from the left, erase pulls from the right
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (above) begin
				data_q <= left;
			end else if (hit) begin
				data_q <= value;
			end
		end else if (cmd.era) begin
			if (above || hit) begin
				data_q <= right;
			end
		end else if (cmd.mdf && hit) begin
			data_q <= value;
		end
	end

	assign data    = data_q;
	assign rd_word = hit ? data_q : '0;

endmodule

[rtl/iiel_or_tree.sv]
// Registered OR tree that collects the one selected word from the row.
module iiel_or_tree #(
	parameter int N = 64,
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         ld1,
	input  logic         ld2,
	input  logic [W-1:0] words [N],
	output logic [W-1:0] result
);
	import iiel_pkg::*;

	localparam int G1 = (N + 7) / 8;
	localparam int G2 = (G1 + 7) / 8;

	logic [W-1:0] pad1 [G1*8];
	logic [W-1:0] lvl1_q [G1];
	logic [W-1:0] pad2 [G2*8];
	logic [W-1:0] lvl2_q [G2];

	// Zero padding up to whole groups of eight
	for (genvar i = 0; i < G1*8; i++) begin : g_pad1
		if (i < N) begin : g_word
			assign pad1[i] = words[i];
		end else begin : g_zero
			assign pad1[i] = '0;
		end
	end

	for (genvar i = 0; i < G2*8; i++) begin : g_pad2
		if (i < G1) begin : g_word
			assign pad2[i] = lvl1_q[i];
		end else begin : g_zero
			assign pad2[i] = '0;
		end
	end

	// First level: eight words per group
	always_ff @(posedge clk) begin
		if (ld1) begin
			for (int g = 0; g < G1; g++) begin
				lvl1_q[g] <= pad1[g*8]   | pad1[g*8+1] | pad1[g*8+2] | pad1[g*8+3]
				           | pad1[g*8+4] | pad1[g*8+5] | pad1[g*8+6] | pad1[g*8+7];
			end
		end
	end

	// Second level
	always_ff @(posedge clk) begin
		if (ld2) begin
			for (int g = 0; g < G2; g++) begin
				lvl2_q[g] <= pad2[g*8]   | pad2[g*8+1] | pad2[g*8+2] | pad2[g*8+3]
				           | pad2[g*8+4] | pad2[g*8+5] | pad2[g*8+6] | pad2[g*8+7];
			end
		end
	end

	// Final merge of the few remaining groups
	always_comb begin
		result = '0;
		for (int g = 0; g < G2; g++) begin
			result = result | lvl2_q[g];
		end
	end

endmodule

[rtl/indexed_insert_erase_list.sv]
// Indexed insert/erase list: a row of element cells with a registered read-out tree.
// The read result passes the first-level and second-level tree registers, then the output register.
// A new request is not taken until the previous one has left the two-level read-out OR tree.
// Inserts, erases and modifies shift or write the affected cells at the accepting edge.
// A new request is taken while a finished result still waits at the output.
// Reset clears the element count and the handshake state; cell contents are not reset.
module indexed_insert_erase_list #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	iiel_req_if.sink    req,
	iiel_rsp_if.source  rsp
);
	import iiel_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic                  accept;
	logic [CNT_W-1:0]      elem_cnt_q;
	logic [CNT_W-1:0]      cnt_next;
	logic [IW-1:0]         pos_w;
	logic [IW-1:0]         cnt_w;
	logic                  full;
	logic [STATUS_W-1:0]   st;
	logic                  ok;
	cell_cmd_t             cmd;
	logic [ELEM_WIDTH-1:0] val_elem;
	logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [ELEM_WIDTH-1:0] rd_words [CAPACITY];
	logic [ELEM_WIDTH-1:0] tree_out;

	logic                  v_s1, v_s2;
	logic                  rd_en_s1, rd_en_s2;
	logic [COUNT_W-1:0]    cnt_s1, cnt_s2;
	logic [STATUS_W-1:0]   st_s1, st_s2;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     out_data_q;
	logic [COUNT_W-1:0]    out_cnt_q;
	logic [STATUS_W-1:0]   out_st_q;
	logic                  out_load;

	assign req.ready = !v_s1 && !v_s2;
	assign accept    = req.valid && req.ready;

	// Bounds and capacity checks
	assign pos_w = IW'(req.position);
	assign cnt_w = IW'(elem_cnt_q);
	assign full  = (elem_cnt_q == CNT_W'(CAPACITY));

	always_comb begin
		unique case (req.req_type)
			REQ_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else if (pos_w > cnt_w) begin
					st = ST_RANGE;
				end else begin
					st = ST_OK;
				end
			end
			REQ_READ, REQ_ERASE, REQ_MODIFY: begin
				st = (pos_w < cnt_w) ? ST_OK : ST_RANGE;
			end
			default: begin
				st = ST_RANGE;
			end
		endcase
	end

	assign ok = (st == ST_OK);

	// Element count after this request
	always_comb begin
		cnt_next = elem_cnt_q;
		if (ok && req.req_type == REQ_INSERT) begin
			cnt_next = elem_cnt_q + CNT_W'(1);
		end else if (ok && req.req_type == REQ_ERASE) begin
			cnt_next = elem_cnt_q - CNT_W'(1);
		end
	end

	// Command broadcast to the cell row
	assign cmd.ins  = accept && ok && (req.req_type == REQ_INSERT);
	assign cmd.era  = accept && ok && (req.req_type == REQ_ERASE);
	assign cmd.mdf  = accept && ok && (req.req_type == REQ_MODIFY);
	assign cmd.pos  = req.position;
	assign val_elem = ELEM_WIDTH'(req.value);

	// Row of cells, each linked to its neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_w;
		logic [ELEM_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		iiel_cell #(
			.IDX        (i),
			.IW         (IW),
			.ELEM_WIDTH (ELEM_WIDTH)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.value   (val_elem),
			.left    (left_w),
			.right   (right_w),
			.data    (cell_data[i]),
			.rd_word (rd_words[i])
		);
	end

	// Read-out of the selected cell
	iiel_or_tree #(
		.N (CAPACITY),
		.W (ELEM_WIDTH)
	) u_or_tree (
		.clk    (clk),
		.ld1    (accept),
		.ld2    (v_s1),
		.words  (rd_words),
		.result (tree_out)
	);

	// Element count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= '0;
		end else if (accept) begin
			elem_cnt_q <= cnt_next;
		end
	end

	// Pipeline valid bits alongside the tree
	assign out_load = v_s2 && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (out_load) begin
				v_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result fields travelling with the tree
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_en_s1 <= ok && (req.req_type == REQ_READ);
			cnt_s1   <= COUNT_W'(cnt_next);
			st_s1    <= st;
		end
		if (v_s1) begin
			rd_en_s2 <= rd_en_s1;
			cnt_s2   <= cnt_s1;
			st_s2    <= st_s1;
		end
		if (out_load) begin
			out_data_q <= rd_en_s2 ? DATA_W'(tree_out) : '0;
			out_cnt_q  <= cnt_s2;
			out_st_q   <= st_s2;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_data_q;
	assign rsp.count      = out_cnt_q;
	assign rsp.status     = out_st_q;

endmodule

[tb/tb.sv]
// Testbench for the indexed insert/erase list: directed and random requests, scoreboard check.
module tb;
	import iiel_pkg::*;

	localparam int LIST_CAP   = 64;
	localparam int N_ITEMS    = 1950;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] kind;
		logic [POS_W-1:0]      pos;
		logic [DATA_W-1:0]     val;
	} list_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]   read_value;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
	} list_rsp_t;

	typedef enum int {PROF_FILL, PROF_DRAIN, PROF_MIX, PROF_EDIT} req_profile_t;
	typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PATTERN} stall_mode_t;

	// Mirror of the list contents plus the queue of responses still owed
	class list_scoreboard;
		logic [DATA_W-1:0] cells [LIST_CAP];
		int unsigned       fill;
		list_rsp_t         owed_q [$];
		int unsigned       errors;

		function new();
			fill = 0;
			errors = 0;
			foreach (cells[i]) cells[i] = '0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) $display("mismatch: %s", msg);
		endfunction

		// Apply one accepted request to the mirror and queue its response
		function void note_request(list_req_t r);
			list_rsp_t e;
			e.read_value = '0;
			e.status = ST_OK;
			case (r.kind)
				REQ_READ: begin
					if (r.pos < fill) e.read_value = cells[r.pos];
					else e.status = ST_RANGE;
				end
				REQ_INSERT: begin
					// full is tested before the position
					if (fill >= LIST_CAP) e.status = ST_FULL;
					else if (r.pos > fill) e.status = ST_RANGE;
					else begin
						for (int j = fill; j > r.pos; j--) cells[j] = cells[j-1];
						cells[r.pos] = r.val;
						fill++;
					end
				end
				REQ_ERASE: begin
					if (r.pos < fill) begin
						for (int j = r.pos + 1; j < fill; j++) cells[j-1] = cells[j];
						fill--;
					end else e.status = ST_RANGE;
				end
				default: begin
					if (r.pos < fill) cells[r.pos] = r.val;
					else e.status = ST_RANGE;
				end
			endcase
			e.count = fill[COUNT_W-1:0];
			owed_q.push_back(e);
		endfunction

		function void check_result(list_rsp_t got);
			list_rsp_t e;
			if (owed_q.size() == 0) begin
				report($sformatf("response with none owed: rd=%h cnt=%0d st=%0d",
					got.read_value, got.count, got.status));
				return;
			end
			e = owed_q.pop_front();
			if (got.read_value !== e.read_value || got.count !== e.count ||
			    got.status !== e.status)
				report($sformatf("exp rd=%h cnt=%0d st=%0d, got rd=%h cnt=%0d st=%0d",
					e.read_value, e.count, e.status,
					got.read_value, got.count, got.status));
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	iiel_req_if req_ch();
	iiel_rsp_if rsp_ch();

	indexed_insert_erase_list #(
		.CAPACITY(LIST_CAP),
		.ELEM_WIDTH(DATA_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	list_scoreboard sb = new();
	int unsigned    burst_left;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic list_req_t mk_req(logic [REQ_TYPE_W-1:0] kind, int unsigned pos,
	                                     logic [DATA_W-1:0] val);
		list_req_t r;
		r.kind = kind;
		r.pos = pos[POS_W-1:0];
		r.val = val;
		return r;
	endfunction

	// Present one item, hold it until taken, then maybe pause before the next burst
	task automatic send_item(list_req_t r);
		int unsigned gap;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.position <= r.pos;
		req_ch.value <= r.val;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				req_ch.req_type <= REQ_TYPE_W'($urandom);
				req_ch.position <= POS_W'($urandom);
				req_ch.value <= $urandom;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Random request shaped by the current profile and the mirrored fill level
	function automatic list_req_t rand_req(req_profile_t prof, int unsigned fill);
		list_req_t r;
		int unsigned pick;
		int unsigned top;
		pick = $urandom_range(0, 99);
		case (prof)
			PROF_FILL:  r.kind = (pick < 70) ? REQ_INSERT : (pick < 80) ? REQ_READ :
			                     (pick < 90) ? REQ_ERASE : REQ_MODIFY;
			PROF_DRAIN: r.kind = (pick < 70) ? REQ_ERASE : (pick < 80) ? REQ_READ :
			                     (pick < 90) ? REQ_INSERT : REQ_MODIFY;
			PROF_EDIT:  r.kind = (pick < 40) ? REQ_READ : (pick < 80) ? REQ_MODIFY :
			                     (pick < 90) ? REQ_INSERT : REQ_ERASE;
			default:    r.kind = pick[1:0];
		endcase
		if ($urandom_range(0, 6) == 0) r.pos = POS_W'($urandom_range(0, 127));
		else begin
			top = (r.kind == REQ_INSERT) ? fill : ((fill == 0) ? 0 : fill - 1);
			case ($urandom_range(0, 3))
				0:       r.pos = '0;
				1:       r.pos = top[POS_W-1:0];
				default: r.pos = POS_W'($urandom_range(0, top));
			endcase
		end
		case ($urandom_range(0, 5))
			0:       r.val = '0;
			1:       r.val = '1;
			2:       r.val = 32'd1 << $urandom_range(0, 31);
			default: r.val = $urandom;
		endcase
		return r;
	endfunction

	// Boundaries and every request kind on a small list
	task automatic run_directed();
		send_item(mk_req(REQ_READ, 0, '0));
		send_item(mk_req(REQ_ERASE, 0, '0));
		send_item(mk_req(REQ_MODIFY, 0, 32'h1234_5678));
		send_item(mk_req(REQ_INSERT, 1, 32'h0000_0001));
		send_item(mk_req(REQ_INSERT, 127, 32'hFFFF_FFFF));
		send_item(mk_req(REQ_INSERT, 0, 32'h0000_0000));
		send_item(mk_req(REQ_INSERT, 1, 32'hFFFF_FFFF));
		send_item(mk_req(REQ_INSERT, 0, 32'hA5A5_A5A5));
		send_item(mk_req(REQ_INSERT, 1, 32'h5A5A_5A5A));
		for (int i = 0; i < 4; i++) send_item(mk_req(REQ_READ, i, $urandom));
		send_item(mk_req(REQ_READ, 4, '0));
		send_item(mk_req(REQ_READ, 64, '0));
		send_item(mk_req(REQ_READ, 127, '0));
		send_item(mk_req(REQ_MODIFY, 3, 32'h8000_0000));
		send_item(mk_req(REQ_MODIFY, 4, 32'h7FFF_FFFF));
		send_item(mk_req(REQ_ERASE, 0, '1));
		send_item(mk_req(REQ_ERASE, 2, '0));
		send_item(mk_req(REQ_ERASE, 64, '0));
		send_item(mk_req(REQ_READ, 0, '0));
		send_item(mk_req(REQ_READ, 1, '0));
	endtask

	// Stimulus and end of run
	initial begin
		int unsigned  span;
		int unsigned  sent;
		req_profile_t prof;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= '0;
		req_ch.position <= '0;
		req_ch.value <= '0;
		burst_left = $urandom_range(1, 40);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		run_directed();
		sent = 23;
		while (sent < N_ITEMS) begin
			prof = req_profile_t'($urandom_range(0, 3));
			span = $urandom_range(60, 250);
			repeat (span) begin
				if (sent < N_ITEMS) begin
					send_item(rand_req(prof, sb.fill));
					sent++;
				end
			end
		end
		if (burst_left != 0) req_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Response side: check each taken item, stall in changing modes
	initial begin
		stall_mode_t mode;
		int unsigned left;
		int unsigned phase;
		logic [7:0]  mask;
		list_rsp_t   got;
		rsp_ch.ready <= 1'b0;
		mode = RDY_ALWAYS;
		left = 0;
		phase = 0;
		mask = 8'hFF;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.read_value = rsp_ch.read_value;
				got.count = rsp_ch.count;
				got.status = rsp_ch.status;
				sb.check_result(got);
			end
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 200);
				mask = 8'($urandom_range(1, 255));
			end
			left--;
			phase++;
			case (mode)
				RDY_ALWAYS: rsp_ch.ready <= 1'b1;
				RDY_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default:    rsp_ch.ready <= mask[phase % 8];
			endcase
		end
	end

	// Watchdog: too long without any item moving on either channel
	initial begin
		int unsigned idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
			else idle++;
		end
		$display("FAIL");
		$finish;
	end

endmodule
